### hw/rtl/scba_pkg.sv
// Package for the size class block allocator: pool geometry, status, class
// and action codes, word types and the block offset function.
// Depends on nothing; used by size_class_block_allocator_unit.
package scba_pkg;

    // Pool geometry
    localparam int SMALL_BLOCKS  = 8;
    localparam int MEDIUM_BLOCKS = 8;
    localparam int LARGE_BLOCKS  = 4;
    localparam int HEADER_BYTES  = 8;

    localparam int NUM_CLASSES  = 3;
    localparam int TOTAL_BLOCKS = SMALL_BLOCKS + MEDIUM_BLOCKS + LARGE_BLOCKS;
    localparam int BLK_W        = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
    localparam int ADDR_W       = 16;

    localparam int SIZE_SMALL  = 16;
    localparam int SIZE_MEDIUM = 32;
    localparam int SIZE_LARGE  = 64;

    localparam int SHIFT_SMALL  = $clog2(SIZE_SMALL);
    localparam int SHIFT_MEDIUM = $clog2(SIZE_MEDIUM);
    localparam int SHIFT_LARGE  = $clog2(SIZE_LARGE);

    localparam int FIRST_SMALL  = 0;
    localparam int FIRST_MEDIUM = SMALL_BLOCKS;
    localparam int FIRST_LARGE  = SMALL_BLOCKS + MEDIUM_BLOCKS;

    localparam int SPAN_SMALL  = SMALL_BLOCKS * SIZE_SMALL;
    localparam int SPAN_MEDIUM = MEDIUM_BLOCKS * SIZE_MEDIUM;
    localparam int SPAN_LARGE  = LARGE_BLOCKS * SIZE_LARGE;

    localparam int OFF_MEDIUM = SPAN_SMALL;
    localparam int OFF_LARGE  = SPAN_SMALL + SPAN_MEDIUM;

    // Largest payload each class carries
    localparam int FIT_SMALL  = SIZE_SMALL - HEADER_BYTES;
    localparam int FIT_MEDIUM = SIZE_MEDIUM - HEADER_BYTES;
    localparam int FIT_LARGE  = SIZE_LARGE - HEADER_BYTES;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_BAD_FREE  = 2'd3;

    // Size class codes
    localparam logic [1:0] CLS_SMALL  = 2'd0;
    localparam logic [1:0] CLS_MEDIUM = 2'd1;
    localparam logic [1:0] CLS_LARGE  = 2'd2;

    // Action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef logic [BLK_W-1:0]  blk_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic       action;
        addr_t      request_bytes;
        addr_t      release_address;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        addr_t      user_address;
        logic [1:0] size_class;
    } rsp_t;

    // Byte offset of a block (global index) from the area base
    function automatic addr_t block_offset(input logic [1:0] cls, input blk_t blk);
        addr_t off;
        case (cls)
            CLS_SMALL:
                off = (addr_t'(blk) - addr_t'(FIRST_SMALL)) << SHIFT_SMALL;
            CLS_MEDIUM:
                off = addr_t'(OFF_MEDIUM)
                    + ((addr_t'(blk) - addr_t'(FIRST_MEDIUM)) << SHIFT_MEDIUM);
            CLS_LARGE:
                off = addr_t'(OFF_LARGE)
                    + ((addr_t'(blk) - addr_t'(FIRST_LARGE)) << SHIFT_LARGE);
            default:
                off = '0;
        endcase
        return off;
    endfunction

endpackage

### hw/rtl/size_class_block_allocator_unit.sv
// Top level of the size class block allocator: request register, free-list
// state in flip-flops and result register.
// Depends on scba_pkg.

// Three pools of 16-, 32- and 64-byte blocks lie back to back from area_base,
// each with its own LIFO free list held in flip-flops. A request is taken at
// any edge where start is high; busy stays low, so one request per clock is
// sustained. done and the result are registered together at the edge after
// the request edge; the result is shown for exactly one cycle, one result per
// request, in order; the receiver cannot hold it off. Between the request
// register and the result register lies one read of a class head and its
// link, with the head and link written back at the edge that loads the result.
// The user must write area_base through cfg_valid/cfg_data (cfg_ready is always
// high) only while no request is outstanding; the block does not enforce it.
// A double free is not detected.
module size_class_block_allocator_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  scba_pkg::req_t      request,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  scba_pkg::addr_t     cfg_data,
    output logic                done,
    output scba_pkg::rsp_t      result
);

    // Configuration and free-list state
    scba_pkg::addr_t                   area_base_reg;
    scba_pkg::blk_t                    next_free_reg [scba_pkg::TOTAL_BLOCKS];
    logic [scba_pkg::TOTAL_BLOCKS-1:0] next_valid_reg;
    scba_pkg::blk_t                    head_reg [scba_pkg::NUM_CLASSES];
    logic [scba_pkg::NUM_CLASSES-1:0]  head_valid_reg;

    // Request and result stages
    logic                              in_valid_reg;
    scba_pkg::req_t                    in_reg;
    logic                              done_reg;
    scba_pkg::rsp_t                    rsp_reg;
    scba_pkg::rsp_t                    rsp_next;

    // Allocate path
    logic                              a_fit;
    logic [1:0]                        a_cls;
    scba_pkg::blk_t                    a_blk;
    logic                              a_ok;
    scba_pkg::addr_t                   a_addr;

    // Free path
    scba_pkg::addr_t                   f_off0;
    scba_pkg::addr_t                   f_off1;
    scba_pkg::addr_t                   f_off2;
    logic                              f_ok;
    logic [1:0]                        f_cls;
    scba_pkg::blk_t                    f_blk;

    logic                              pop_en;
    logic                              push_en;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = rsp_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_base_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            area_base_reg <= cfg_data;
        end
    end

    // Request valid and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    // Capture request word, register result word
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= request;
        end
        rsp_reg <= rsp_next;
    end

    // Pick the first class that fits and look at its head
    always_comb
    begin
        a_fit = 1'b1;
        a_cls = scba_pkg::CLS_SMALL;
        if (in_reg.request_bytes <= scba_pkg::addr_t'(scba_pkg::FIT_SMALL))
        begin
            a_cls = scba_pkg::CLS_SMALL;
        end
        else if (in_reg.request_bytes <= scba_pkg::addr_t'(scba_pkg::FIT_MEDIUM))
        begin
            a_cls = scba_pkg::CLS_MEDIUM;
        end
        else if (in_reg.request_bytes <= scba_pkg::addr_t'(scba_pkg::FIT_LARGE))
        begin
            a_cls = scba_pkg::CLS_LARGE;
        end
        else
        begin
            a_fit = 1'b0;
        end
        a_blk  = head_reg[a_cls];
        a_ok   = a_fit && head_valid_reg[a_cls]
               && ({1'b0, a_blk} < (scba_pkg::BLK_W + 1)'(scba_pkg::TOTAL_BLOCKS));
        a_addr = area_base_reg + scba_pkg::block_offset(a_cls, a_blk)
               + scba_pkg::addr_t'(scba_pkg::HEADER_BYTES);
    end

    // Decode class and block from a release address
    always_comb
    begin
        f_off0 = in_reg.release_address - scba_pkg::addr_t'(scba_pkg::HEADER_BYTES)
               - area_base_reg;
        f_off1 = f_off0 - scba_pkg::addr_t'(scba_pkg::SPAN_SMALL);
        f_off2 = f_off1 - scba_pkg::addr_t'(scba_pkg::SPAN_MEDIUM);
        f_ok   = 1'b0;
        f_cls  = scba_pkg::CLS_SMALL;
        f_blk  = '0;
        if (f_off0 < scba_pkg::addr_t'(scba_pkg::SPAN_SMALL))
        begin
            f_cls = scba_pkg::CLS_SMALL;
            f_ok  = (f_off0 & scba_pkg::addr_t'(scba_pkg::SIZE_SMALL - 1)) == '0;
            f_blk = scba_pkg::blk_t'(scba_pkg::FIRST_SMALL)
                  + scba_pkg::blk_t'(f_off0 >> scba_pkg::SHIFT_SMALL);
        end
        else if (f_off1 < scba_pkg::addr_t'(scba_pkg::SPAN_MEDIUM))
        begin
            f_cls = scba_pkg::CLS_MEDIUM;
            f_ok  = (f_off1 & scba_pkg::addr_t'(scba_pkg::SIZE_MEDIUM - 1)) == '0;
            f_blk = scba_pkg::blk_t'(scba_pkg::FIRST_MEDIUM)
                  + scba_pkg::blk_t'(f_off1 >> scba_pkg::SHIFT_MEDIUM);
        end
        else if (f_off2 < scba_pkg::addr_t'(scba_pkg::SPAN_LARGE))
        begin
            f_cls = scba_pkg::CLS_LARGE;
            f_ok  = (f_off2 & scba_pkg::addr_t'(scba_pkg::SIZE_LARGE - 1)) == '0;
            f_blk = scba_pkg::blk_t'(scba_pkg::FIRST_LARGE)
                  + scba_pkg::blk_t'(f_off2 >> scba_pkg::SHIFT_LARGE);
        end
    end

    // Form the result word and the list updates
    always_comb
    begin
        pop_en   = 1'b0;
        push_en  = 1'b0;
        rsp_next = '{status: scba_pkg::ST_OK, user_address: '0,
                     size_class: scba_pkg::CLS_SMALL};
        if (in_valid_reg)
        begin
            case (in_reg.action)
                scba_pkg::ACT_ALLOC:
                begin
                    pop_en = a_ok;
                    if (!a_fit)
                    begin
                        rsp_next.status = scba_pkg::ST_TOO_LARGE;
                    end
                    else
                    begin
                        rsp_next.size_class = a_cls;
                        rsp_next.status     = a_ok ? scba_pkg::ST_OK
                                                   : scba_pkg::ST_EXHAUSTED;
                        if (a_ok)
                        begin
                            rsp_next.user_address = a_addr;
                        end
                    end
                end
                scba_pkg::ACT_FREE:
                begin
                    push_en = f_ok;
                    if (f_ok)
                    begin
                        rsp_next.size_class = f_cls;
                    end
                    else
                    begin
                        rsp_next.status = scba_pkg::ST_BAD_FREE;
                    end
                end
                default:
                begin
                    rsp_next.status = scba_pkg::ST_BAD_FREE;
                end
            endcase
        end
    end

    // Free lists: ascending chain per class after reset; pop or push per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scba_pkg::TOTAL_BLOCKS; i++)
            begin
                next_free_reg[i]  <= scba_pkg::blk_t'(i + 1);
                next_valid_reg[i] <= !((i == scba_pkg::FIRST_MEDIUM - 1)
                                    || (i == scba_pkg::FIRST_LARGE - 1)
                                    || (i == scba_pkg::TOTAL_BLOCKS - 1));
            end
            head_reg[scba_pkg::CLS_SMALL]  <= scba_pkg::blk_t'(scba_pkg::FIRST_SMALL);
            head_reg[scba_pkg::CLS_MEDIUM] <= scba_pkg::blk_t'(scba_pkg::FIRST_MEDIUM);
            head_reg[scba_pkg::CLS_LARGE]  <= scba_pkg::blk_t'(scba_pkg::FIRST_LARGE);
            head_valid_reg <= '1;
        end
        else if (pop_en)
        begin
            head_reg[a_cls]       <= next_free_reg[a_blk];
            head_valid_reg[a_cls] <= next_valid_reg[a_blk];
        end
        else if (push_en)
        begin
            next_free_reg[f_blk]  <= head_reg[f_cls];
            next_valid_reg[f_blk] <= head_valid_reg[f_cls];
            head_reg[f_cls]       <= f_blk;
            head_valid_reg[f_cls] <= 1'b1;
        end
    end

    // Every accepted request is later followed by done
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
    else $error("request accepted without a result two cycles later");

    // Only a successful allocate gives out an address
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != scba_pkg::ST_OK)) |-> (result.user_address == '0))
    else $error("failed request returned a non-zero address");

    // An oversized request reports the small class
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == scba_pkg::ST_TOO_LARGE))
            |-> (result.size_class == scba_pkg::CLS_SMALL))
    else $error("oversized request reported a class");

    // A class list can run empty only through an allocate
    assert property (@(posedge clk) disable iff (!rst_n)
        (($past(head_valid_reg) & ~head_valid_reg) != '0)
            |-> $past(in_valid_reg && (in_reg.action == scba_pkg::ACT_ALLOC)))
    else $error("class head lost its valid bit without an allocate");

endmodule

### bench/tb.sv
// Self-checking bench for size_class_block_allocator_unit: directed and random
// allocate and free words, checked against a free-list model kept in the bench.
// Depends on scba_pkg and the allocator RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scba_pkg::*;

    localparam int POOL_SPAN  = OFF_LARGE + SPAN_LARGE;
    localparam int IDLE_LIMIT = 2000;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  start     = 1'b0;
    req_t  request   = '0;
    logic  cfg_valid = 1'b0;
    addr_t cfg_data  = '0;
    logic  busy;
    logic  cfg_ready;
    logic  done;
    rsp_t  result;

    // Free-list model: one link per block, one head per class
    blk_t  pool_link    [TOTAL_BLOCKS];
    logic  pool_link_ok [TOTAL_BLOCKS];
    blk_t  pool_head    [NUM_CLASSES];
    logic  pool_head_ok [NUM_CLASSES];
    addr_t area_base;

    rsp_t  pending_rsp [$];
    addr_t live_blocks [$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    bit    no_gaps = 1'b0;

    size_class_block_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    always #6 clk = ~clk;

    // Chain each class in ascending order, last link null
    function automatic void pool_reset();
        int unsigned first_of [NUM_CLASSES];
        int unsigned count_of [NUM_CLASSES];
        first_of = '{FIRST_SMALL, FIRST_MEDIUM, FIRST_LARGE};
        count_of = '{SMALL_BLOCKS, MEDIUM_BLOCKS, LARGE_BLOCKS};
        area_base = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            pool_head[c]    = blk_t'(first_of[c]);
            pool_head_ok[c] = 1'b1;
            for (int i = 0; i < count_of[c]; i++)
            begin
                pool_link[first_of[c] + i]    = blk_t'(first_of[c] + i + 1);
                pool_link_ok[first_of[c] + i] = (i + 1 < count_of[c]);
            end
        end
    endfunction

    // Apply one request word to the free lists and return the expected result
    function automatic rsp_t pool_step(input req_t w);
        rsp_t        rsp;
        int unsigned bytes_of [NUM_CLASSES];
        int unsigned count_of [NUM_CLASSES];
        int unsigned first_of [NUM_CLASSES];
        int unsigned blk;
        int unsigned boff;
        int unsigned off;
        int unsigned span;
        addr_t       woff;
        bit          found;
        bytes_of = '{SIZE_SMALL, SIZE_MEDIUM, SIZE_LARGE};
        count_of = '{SMALL_BLOCKS, MEDIUM_BLOCKS, LARGE_BLOCKS};
        first_of = '{FIRST_SMALL, FIRST_MEDIUM, FIRST_LARGE};
        rsp.user_address = '0;
        rsp.size_class   = CLS_SMALL;
        found            = 1'b0;
        if (w.action == ACT_ALLOC)
        begin
            // Pick the first class that holds the payload, pop its head
            rsp.status = ST_TOO_LARGE;
            for (int c = 0; c < NUM_CLASSES && !found; c++)
            begin
                if (w.request_bytes <= bytes_of[c] - HEADER_BYTES)
                begin
                    found          = 1'b1;
                    rsp.size_class = 2'(c);
                    if (!pool_head_ok[c])
                        rsp.status = ST_EXHAUSTED;
                    else
                    begin
                        blk             = pool_head[c];
                        rsp.status      = ST_OK;
                        pool_head[c]    = pool_link[blk];
                        pool_head_ok[c] = pool_link_ok[blk];
                        boff = 0;
                        for (int k = 0; k < c; k++)
                            boff += count_of[k] * bytes_of[k];
                        boff += (blk - first_of[c]) * bytes_of[c];
                        rsp.user_address = addr_t'(area_base + boff + HEADER_BYTES);
                    end
                end
            end
        end
        else
        begin
            // Decode class and block from the wrapped offset, push the block
            rsp.status = ST_BAD_FREE;
            woff = w.release_address - addr_t'(HEADER_BYTES) - area_base;
            off  = woff;
            for (int c = 0; c < NUM_CLASSES && !found; c++)
            begin
                span = count_of[c] * bytes_of[c];
                if (off < span)
                begin
                    found = 1'b1;
                    if (off % bytes_of[c] == 0)
                    begin
                        blk               = first_of[c] + off / bytes_of[c];
                        pool_link[blk]    = pool_head[c];
                        pool_link_ok[blk] = pool_head_ok[c];
                        pool_head[c]      = blk_t'(blk);
                        pool_head_ok[c]   = 1'b1;
                        rsp.status        = ST_OK;
                        rsp.size_class    = 2'(c);
                    end
                end
                else
                    off -= span;
            end
        end
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch in %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Predict on each accepted word, check each result word against the oldest
    always @(posedge clk)
    begin : result_check
        rsp_t want;
        rsp_t next_rsp;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                next_rsp = pool_step(request);
                pending_rsp.push_back(next_rsp);
                if (request.action == ACT_ALLOC && next_rsp.status == ST_OK)
                    live_blocks.push_back(next_rsp.user_address);
            end
            if (done)
            begin
                if (pending_rsp.size() == 0)
                    report_mismatch("result with nothing outstanding", 1, 0);
                else
                begin
                    want = pending_rsp.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                    if (result.user_address !== want.user_address)
                        report_mismatch("user_address", result.user_address,
                                        want.user_address);
                    if (result.size_class !== want.size_class)
                        report_mismatch("size_class", result.size_class, want.size_class);
                end
            end
            if (cfg_valid && cfg_ready)
                area_base = cfg_data;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // Mostly short gaps, a few long ones, none during a burst stretch
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic addr_t pick_request();
        case ($urandom_range(0, 9))
            0, 1, 2: return addr_t'($urandom_range(0, FIT_SMALL));
            3, 4, 5: return addr_t'($urandom_range(FIT_SMALL + 1, FIT_MEDIUM));
            6, 7:    return addr_t'($urandom_range(FIT_MEDIUM + 1, FIT_LARGE));
            8:
            begin
                case ($urandom_range(0, 5))
                    0: return addr_t'(FIT_SMALL);
                    1: return addr_t'(FIT_SMALL + 1);
                    2: return addr_t'(FIT_MEDIUM);
                    3: return addr_t'(FIT_MEDIUM + 1);
                    4: return addr_t'(FIT_LARGE);
                    default: return addr_t'(FIT_LARGE + 1);
                endcase
            end
            default: return addr_t'($urandom);
        endcase
    endfunction

    // Address that never hits a block start, so no free block is pushed twice
    function automatic addr_t pick_stray();
        addr_t a;
        addr_t off;
        case ($urandom_range(0, 2))
            0: a = addr_t'($urandom);
            1: a = area_base + addr_t'(HEADER_BYTES) + addr_t'($urandom_range(0, POOL_SPAN + 60));
            default: a = area_base + addr_t'(HEADER_BYTES) - addr_t'($urandom_range(1, 16));
        endcase
        off = a - addr_t'(HEADER_BYTES) - area_base;
        if (off < POOL_SPAN && off[3:0] == 4'd0)
            a = a + addr_t'(1);
        return a;
    endfunction

    // Present one request word and hold it until accepted; start stays high
    task automatic send_word(input logic act, input addr_t bytes_in, input addr_t addr_in);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= '{action: act, request_bytes: bytes_in, release_address: addr_in};
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic do_alloc(input addr_t bytes_in);
        send_word(ACT_ALLOC, bytes_in, addr_t'($urandom));
    endtask

    task automatic do_free(input addr_t addr_in);
        send_word(ACT_FREE, addr_t'($urandom), addr_in);
    endtask

    // Free every block still handed out, in random order
    task automatic release_all();
        addr_t a;
        int    idx;
        start <= 1'b0;
        @(posedge clk);
        while (live_blocks.size() != 0)
        begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            a   = live_blocks[idx];
            live_blocks.delete(idx);
            do_free(a);
        end
    endtask

    // Drain, let the pipeline settle, then write the base register
    task automatic write_area_base(input addr_t value);
        start <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Class boundaries, oversized requests and an exhausted large class
    task automatic test_request_classes();
        do_alloc(addr_t'(0));
        do_alloc(addr_t'(FIT_SMALL));
        do_alloc(addr_t'(FIT_SMALL + 1));
        do_alloc(addr_t'(FIT_MEDIUM));
        do_alloc(addr_t'(FIT_MEDIUM + 1));
        do_alloc(addr_t'(FIT_LARGE));
        do_alloc(addr_t'(FIT_LARGE + 1));
        do_alloc(16'hFFFF);
        do_alloc(addr_t'(FIT_LARGE));
        do_alloc(addr_t'(FIT_LARGE));
        do_alloc(addr_t'(40));
    endtask

    // Addresses below, inside and past the pools, then good frees per class
    task automatic test_bad_release();
        addr_t a;
        do_free(16'h0000);
        do_free(area_base + addr_t'(HEADER_BYTES + 4));
        do_free(area_base + addr_t'(HEADER_BYTES + POOL_SPAN));
        do_free(16'hFFFF);
        do_free(area_base + addr_t'(HEADER_BYTES + OFF_MEDIUM + SIZE_SMALL));
        a = live_blocks.pop_back();
        do_free(a);
        a = live_blocks.pop_front();
        do_free(a);
        a = live_blocks[1];
        live_blocks.delete(1);
        do_free(a);
    endtask

    // Mostly allocate and free of handed-out blocks, some stray frees
    task automatic test_random_traffic(input int count);
        int    roll;
        int    idx;
        addr_t a;
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (count)
        begin
            if ($urandom_range(0, 29) == 0)
                no_gaps = !no_gaps;
            roll = $urandom_range(0, 99);
            if (roll < 55)
                do_alloc(pick_request());
            else if (roll < 90 && live_blocks.size() != 0)
            begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                a   = live_blocks[idx];
                live_blocks.delete(idx);
                do_free(a);
            end
            else
                do_free(pick_stray());
        end
        no_gaps = 1'b0;
        release_all();
    endtask

    // Free one small block twice; run last, as the small list stays cyclic
    task automatic test_double_free();
        addr_t a;
        do_alloc(addr_t'(0));
        start <= 1'b0;
        @(posedge clk);
        a = live_blocks.pop_back();
        do_free(a);
        do_free(a);
        repeat (3) do_alloc(addr_t'($urandom_range(0, FIT_SMALL)));
    endtask

    initial
    begin
        pool_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_request_classes();
        test_bad_release();
        test_random_traffic(135);
        write_area_base(addr_t'(64896));
        test_random_traffic(135);
        write_area_base(addr_t'($urandom_range(1, 64895)));
        test_random_traffic(135);
        write_area_base(addr_t'(0));
        test_random_traffic(135);
        write_area_base(addr_t'($urandom_range(0, 32447) * 2 + 1));
        test_random_traffic(135);
        write_area_base(addr_t'($urandom_range(0, 64896)));
        test_random_traffic(135);
        test_double_free();

        // Hold off, then wait for every outstanding result
        start <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
